// File: rtl/lrtl_pkg.sv
// ----------------------------------------------------------------------------
// lrtl_pkg
// Shared types and constants of the ramping light-level controller with
// low-cell and thermal limiting.
// ----------------------------------------------------------------------------
package lrtl_pkg;

  localparam int unsigned LEVEL_W = 12;
  localparam int unsigned CELL_W  = 8;
  localparam int unsigned TEMP_W  = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  typedef enum logic [1:0] {
    MODE_UP      = 2'd0,
    MODE_STEADY  = 2'd1,
    MODE_DOWN    = 2'd2,
    MODE_THERMAL = 2'd3
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_CELL     = 3'd0,
    REG_FULL_CELL    = 3'd1,
    REG_LEVEL_MIN    = 3'd2,
    REG_LEVEL_MAX    = 3'd3,
    REG_THERMAL_THR  = 3'd4,
    REG_STORED_LIMIT = 3'd5
  } cfg_reg_t;

  localparam logic [CELL_W-1:0]  RST_LOW_CELL     = 8'd150;
  localparam logic [CELL_W-1:0]  RST_FULL_CELL    = 8'd210;
  localparam logic [LEVEL_W-1:0] RST_LEVEL_MIN    = 12'd120;
  localparam logic [LEVEL_W-1:0] RST_LEVEL_MAX    = 12'd450;
  localparam logic [LEVEL_W-1:0] RST_THERMAL_THR  = 12'd180;
  localparam logic [TEMP_W-1:0]  RST_STORED_LIMIT = 8'd128;

  localparam logic [CNT_W-1:0]   CLICK_RESET_TICK = 8'd20;
  localparam logic [CNT_W-1:0]   CLICK_THERMAL    = 8'd10;
  localparam logic [LEVEL_W:0]   SHUTDOWN_MARGIN  = 13'd10;
  localparam logic [LEVEL_W-1:0] LEVEL_TOP        = 12'hFFF;
  localparam logic [CELL_W-1:0]  CELL_TOP         = 8'hFF;

endpackage

// File: rtl/led_ramp_thermal_limiter.sv
// ----------------------------------------------------------------------------
// led_ramp_thermal_limiter
// Click-driven ramping light controller with low-cell step limiting,
// temperature limiting, shutdown and cell reading filter.
// ----------------------------------------------------------------------------
// One item (tick or power-on event) is taken every clock cycle unless the
// result side stalls. Each item passes an input register and then a result
// register, from which its result is taken. Every item reads and writes the
// controller state as it moves from the input register to the result
// register, through a short path of compares and one 14-bit add. A stalled
// result holds the result register and, once the input register is also
// full, the input side.
// Configuration writes are taken in every cycle outside reset.
module led_ramp_thermal_limiter (
  input  logic                                 clk,
  input  logic                                 rst,
  // event channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 op,
  input  logic [15:0]                          temp_count,
  input  logic [lrtl_pkg::CELL_W-1:0]          cell_sample,
  input  logic                                 memory_kept,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lrtl_pkg::LEVEL_W-1:0]         light_level,
  output logic                                 full_on,
  output logic                                 idle_sleep,
  output logic                                 shut_down,
  output logic                                 save_limit,
  output logic [lrtl_pkg::TEMP_W-1:0]          temp_limit_out,
  output logic [lrtl_pkg::LEVEL_W-1:0]         user_level_out,
  output logic [1:0]                           mode_out,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lrtl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lrtl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration registers
  logic [lrtl_pkg::CELL_W-1:0]  low_cell_level;
  logic [lrtl_pkg::CELL_W-1:0]  full_cell_level;
  logic [lrtl_pkg::LEVEL_W-1:0] level_min;
  logic [lrtl_pkg::LEVEL_W-1:0] level_max;
  logic [lrtl_pkg::LEVEL_W-1:0] thermal_threshold;
  logic [lrtl_pkg::TEMP_W-1:0]  stored_temp_limit;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_cell_level    <= lrtl_pkg::RST_LOW_CELL;
      full_cell_level   <= lrtl_pkg::RST_FULL_CELL;
      level_min         <= lrtl_pkg::RST_LEVEL_MIN;
      level_max         <= lrtl_pkg::RST_LEVEL_MAX;
      thermal_threshold <= lrtl_pkg::RST_THERMAL_THR;
      stored_temp_limit <= lrtl_pkg::RST_STORED_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lrtl_pkg::REG_LOW_CELL:     low_cell_level    <= cfg_data[lrtl_pkg::CELL_W-1:0];
        lrtl_pkg::REG_FULL_CELL:    full_cell_level   <= cfg_data[lrtl_pkg::CELL_W-1:0];
        lrtl_pkg::REG_LEVEL_MIN:    level_min         <= cfg_data;
        lrtl_pkg::REG_LEVEL_MAX:    level_max         <= cfg_data;
        lrtl_pkg::REG_THERMAL_THR:  thermal_threshold <= cfg_data;
        lrtl_pkg::REG_STORED_LIMIT: stored_temp_limit <= cfg_data[lrtl_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                        s1_valid;
  logic                        s1_op;
  logic [15:0]                 s1_temp_count;
  logic [lrtl_pkg::CELL_W-1:0] s1_cell_sample;
  logic                        s1_memory_kept;
  logic                        s1_adv;
  logic                        fire;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = rst || (s1_valid && !s1_adv);
  assign fire     = s1_valid && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op          <= op;
      s1_temp_count  <= temp_count;
      s1_cell_sample <= cell_sample;
      s1_memory_kept <= memory_kept;
    end
  end

  // controller state
  lrtl_pkg::mode_t              mode, mode_next;
  logic [lrtl_pkg::LEVEL_W-1:0] user_level, user_level_next;
  logic [lrtl_pkg::LEVEL_W-1:0] drive_level, drive_level_next;
  logic [lrtl_pkg::CELL_W-1:0]  filtered_cell, filtered_cell_next;
  logic [lrtl_pkg::TEMP_W-1:0]  heat_limit, heat_limit_next;
  logic [lrtl_pkg::CNT_W-1:0]   clicks, clicks_next;
  logic [lrtl_pkg::CNT_W-1:0]   tick_count, tick_count_next;
  logic                         ramp_down_phase, ramp_down_phase_next;
  logic                         memory_marked, memory_marked_next;
  logic                         halted, halted_next;

  // result of this item
  logic [lrtl_pkg::LEVEL_W-1:0] res_level;
  logic                         res_full, res_idle, res_shut, res_save;

  // datapath pieces
  logic [lrtl_pkg::TEMP_W-1:0]  temperature;
  logic [lrtl_pkg::LEVEL_W-1:0] ul_capped;
  logic [lrtl_pkg::CNT_W-1:0]   click_inc;
  logic signed [8:0]            cell_diff;
  logic signed [7:0]            step_cell;
  logic signed [7:0]            step_temp;
  logic signed [7:0]            step;
  logic                         thermal_on;
  logic signed [13:0]           lvl_sum;
  logic [lrtl_pkg::LEVEL_W-1:0] lvl_sat;
  logic [lrtl_pkg::LEVEL_W-1:0] lvl;
  logic                         go_dark;
  logic [lrtl_pkg::CELL_W-1:0]  cell_hi, cell_lo, cell_tmp, cell_filt;

  assign temperature = s1_temp_count[8:1];
  assign ul_capped   = (user_level >= level_max) ? level_max : user_level;
  assign click_inc   = clicks + 8'd1;

  // low-cell margin, saturated to a signed byte
  assign cell_diff = $signed({1'b0, filtered_cell}) - $signed({1'b0, low_cell_level});
  always_comb begin
    if (cell_diff > 9'sd127) begin
      step_cell = 8'sd127;
    end else if (cell_diff < -9'sd128) begin
      step_cell = -8'sd128;
    end else begin
      step_cell = cell_diff[7:0];
    end
  end

  // negated sign of the over-temperature
  always_comb begin
    if (temperature > heat_limit) begin
      step_temp = -8'sd1;
    end else if (temperature == heat_limit) begin
      step_temp = 8'sd0;
    end else begin
      step_temp = 8'sd1;
    end
  end

  // cell filter window around the fresh sample
  assign cell_hi   = (s1_cell_sample == lrtl_pkg::CELL_TOP) ? lrtl_pkg::CELL_TOP
                                                            : s1_cell_sample + 8'd1;
  assign cell_lo   = (s1_cell_sample == '0) ? '0 : s1_cell_sample - 8'd1;
  assign cell_tmp  = (cell_hi < filtered_cell) ? cell_hi : filtered_cell;
  assign cell_filt = (cell_lo > cell_tmp) ? cell_lo : cell_tmp;

  always_comb begin
    mode_next            = mode;
    user_level_next      = user_level;
    drive_level_next     = drive_level;
    filtered_cell_next   = filtered_cell;
    heat_limit_next      = heat_limit;
    clicks_next          = clicks;
    tick_count_next      = tick_count;
    ramp_down_phase_next = ramp_down_phase;
    memory_marked_next   = memory_marked;
    halted_next          = halted;
    res_level = '0;
    res_full  = 1'b0;
    res_idle  = 1'b0;
    res_shut  = 1'b0;
    res_save  = 1'b0;
    thermal_on = 1'b0;
    step      = step_cell;
    lvl_sum   = '0;
    lvl_sat   = '0;
    lvl       = '0;
    go_dark   = 1'b0;

    if (s1_op) begin
      // power-on event
      filtered_cell_next   = full_cell_level;
      tick_count_next      = '0;
      ramp_down_phase_next = 1'b0;
      halted_next          = 1'b0;
      user_level_next      = ul_capped;
      if (memory_marked && s1_memory_kept) begin
        clicks_next = click_inc;
        if (click_inc == 8'd1) begin
          case (mode) inside
            lrtl_pkg::MODE_UP, lrtl_pkg::MODE_DOWN: mode_next = lrtl_pkg::MODE_STEADY;
            lrtl_pkg::MODE_STEADY:                  mode_next = lrtl_pkg::MODE_UP;
            default:                                res_save  = 1'b1;
          endcase
        end else if (click_inc == 8'd2) begin
          mode_next = lrtl_pkg::MODE_DOWN;
        end else if (click_inc > lrtl_pkg::CLICK_THERMAL) begin
          mode_next       = lrtl_pkg::MODE_THERMAL;
          user_level_next = level_max;
        end else begin
          mode_next = lrtl_pkg::MODE_STEADY;
        end
      end else begin
        // cold start
        memory_marked_next = 1'b1;
        user_level_next    = level_min;
        mode_next          = lrtl_pkg::MODE_UP;
        clicks_next        = '0;
        heat_limit_next    = stored_temp_limit;
      end
      drive_level_next = user_level_next;
      res_level        = user_level_next;
    end else if (halted) begin
      res_shut = 1'b1;
    end else begin
      tick_count_next = tick_count + 8'd1;
      if (tick_count_next == lrtl_pkg::CLICK_RESET_TICK) begin
        clicks_next = '0;
      end
      if (mode == lrtl_pkg::MODE_THERMAL) begin
        heat_limit_next = temperature;
      end
      if (mode == lrtl_pkg::MODE_UP) begin
        if (user_level < lrtl_pkg::LEVEL_TOP) begin
          user_level_next = user_level + 12'd1;
        end
        if (user_level_next >= level_max) begin
          mode_next = lrtl_pkg::MODE_STEADY;
        end
      end else if (mode == lrtl_pkg::MODE_DOWN) begin
        if (ramp_down_phase) begin
          ramp_down_phase_next = 1'b0;
          if (user_level != '0) begin
            user_level_next = user_level - 12'd1;
          end
          if (user_level_next <= level_min) begin
            mode_next = lrtl_pkg::MODE_STEADY;
          end
        end else begin
          ramp_down_phase_next = 1'b1;
        end
      end

      // thermal mode never changes on a tick, so the old mode decides
      thermal_on = (drive_level >= thermal_threshold) && (mode != lrtl_pkg::MODE_THERMAL);
      if (thermal_on && (step_temp < step_cell)) begin
        step = step_temp;
      end
      lvl_sum = $signed({2'b00, drive_level}) + $signed({{6{step[7]}}, step});
      if (lvl_sum[13]) begin
        lvl_sat = '0;
      end else if (lvl_sum[12]) begin
        lvl_sat = lrtl_pkg::LEVEL_TOP;
      end else begin
        lvl_sat = lvl_sum[11:0];
      end
      lvl = (user_level_next < lvl_sat) ? user_level_next : lvl_sat;

      go_dark = ({1'b0, lvl} + lrtl_pkg::SHUTDOWN_MARGIN) < {1'b0, level_min};
      if (go_dark) begin
        halted_next = 1'b1;
        res_shut    = 1'b1;
      end else begin
        drive_level_next   = lvl;
        filtered_cell_next = cell_filt;
        res_level          = lvl;
        res_full           = (lvl == level_max);
        res_idle           = (lvl >= thermal_threshold);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= lrtl_pkg::MODE_UP;
      user_level      <= lrtl_pkg::RST_LEVEL_MIN;
      drive_level     <= lrtl_pkg::RST_LEVEL_MIN;
      filtered_cell   <= lrtl_pkg::RST_FULL_CELL;
      heat_limit      <= lrtl_pkg::RST_STORED_LIMIT;
      clicks          <= '0;
      tick_count      <= '0;
      ramp_down_phase <= 1'b0;
      memory_marked   <= 1'b0;
      halted          <= 1'b0;
    end else if (fire) begin
      mode            <= mode_next;
      user_level      <= user_level_next;
      drive_level     <= drive_level_next;
      filtered_cell   <= filtered_cell_next;
      heat_limit      <= heat_limit_next;
      clicks          <= clicks_next;
      tick_count      <= tick_count_next;
      ramp_down_phase <= ramp_down_phase_next;
      memory_marked   <= memory_marked_next;
      halted          <= halted_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      light_level    <= res_level;
      full_on        <= res_full;
      idle_sleep     <= res_idle;
      shut_down      <= res_shut;
      save_limit     <= res_save;
      temp_limit_out <= heat_limit_next;
      user_level_out <= user_level_next;
      mode_out       <= mode_next;
    end
  end

  // a dark light reports nothing driven
  a_shut_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && shut_down |-> (light_level == '0) && !full_on && !idle_sleep)
    else $error("shutdown result with light driven");

  // a save request comes only from a click while in thermal config
  a_save_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && save_limit |-> (mode_out == lrtl_pkg::MODE_THERMAL) && !shut_down)
    else $error("save request outside thermal config");

  // the driven level never exceeds the user level
  a_level_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !shut_down |-> light_level <= user_level_out)
    else $error("driven level above user level");

  // ticks while halted leave the drive level alone
  a_halt_hold: assert property (@(posedge clk) disable iff (rst)
    fire && halted && !s1_op |=> $stable(drive_level) && halted)
    else $error("halted state changed by a tick");

endmodule

// File: sim/tb_led_ramp_thermal_limiter.sv
// ----------------------------------------------------------------------------
// tb_led_ramp_thermal_limiter
// Self-checking bench for the ramping light controller. A directed table of
// ticks and power-on events covers cold start, clicks, thermal config,
// shutdown and field extremes. Random traffic follows, with click bursts,
// low-cell dips and temperatures at the limit, run under several register
// settings. Each item is predicted on acceptance and every result is
// compared field by field, in order, under random valid gaps and stalls.
// ----------------------------------------------------------------------------
module tb_led_ramp_thermal_limiter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit OP_TICK     = 1'b0;
  localparam bit OP_POWER_ON = 1'b1;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PER_PHASE = 195;

  typedef struct packed {
    logic        op;
    logic [15:0] temp_count;
    logic [7:0]  cell_in;
    logic        mem_kept;
  } light_event_t;

  typedef struct packed {
    logic [11:0]     level;
    logic            full_on;
    logic            idle_sleep;
    logic            shut_down;
    logic            save_limit;
    logic [7:0]      heat_limit;
    logic [11:0]     user_level;
    lrtl_pkg::mode_t mode;
  } light_result_t;

  typedef struct packed {
    light_event_t  ev;
    logic          typed;
    light_result_t res;
  } dir_row_t;

  typedef struct packed {
    logic [7:0]  low_cell;
    logic [7:0]  full_cell;
    logic [11:0] lvl_min;
    logic [11:0] lvl_max;
    logic [11:0] thermal_thr;
    logic [7:0]  stored_limit;
  } settings_t;

  localparam light_result_t NO_RES = '0;

  // typed rows: reset state, cold starts and the low-cell shutdown
  localparam dir_row_t DIRECTED [22] = '{
    '{'{OP_TICK,     16'h0000, 8'd210, 1'b0}, 1'b1,
      '{12'd121, 1'b0, 1'b0, 1'b0, 1'b0, 8'd128, 12'd121, lrtl_pkg::MODE_UP}},
    '{'{OP_POWER_ON, 16'h0000, 8'd0,   1'b1}, 1'b1,
      '{12'd120, 1'b0, 1'b0, 1'b0, 1'b0, 8'd128, 12'd120, lrtl_pkg::MODE_UP}},
    '{'{OP_TICK,     16'hFFFF, 8'd255, 1'b1}, 1'b0, NO_RES},
    '{'{OP_TICK,     16'h0000, 8'd0,   1'b0}, 1'b0, NO_RES},
    '{'{OP_TICK,     16'h0000, 8'd0,   1'b0}, 1'b1,
      '{12'd0,   1'b0, 1'b0, 1'b1, 1'b0, 8'd128, 12'd123, lrtl_pkg::MODE_UP}},
    '{'{OP_TICK,     16'hFFFF, 8'd255, 1'b1}, 1'b1,
      '{12'd0,   1'b0, 1'b0, 1'b1, 1'b0, 8'd128, 12'd123, lrtl_pkg::MODE_UP}},
    '{'{OP_POWER_ON, 16'hFFFF, 8'd255, 1'b1}, 1'b0, NO_RES},
    '{'{OP_POWER_ON, 16'h0000, 8'd0,   1'b1}, 1'b0, NO_RES},
    '{'{OP_TICK,     16'h1234, 8'd200, 1'b0}, 1'b0, NO_RES},
    '{'{OP_TICK,     16'h0100, 8'd180, 1'b0}, 1'b0, NO_RES},
    '{'{OP_POWER_ON, 16'h0000, 8'd0,   1'b1}, 1'b0, NO_RES},
    '{'{OP_POWER_ON, 16'h0000, 8'd0,   1'b1}, 1'b0, NO_RES},
    '{'{OP_POWER_ON, 16'h0000, 8'd0,   1'b1}, 1'b0, NO_RES},
    '{'{OP_POWER_ON, 16'h0000, 8'd0,   1'b1}, 1'b0, NO_RES},
    '{'{OP_POWER_ON, 16'h0000, 8'd0,   1'b1}, 1'b0, NO_RES},
    '{'{OP_POWER_ON, 16'h0000, 8'd0,   1'b1}, 1'b0, NO_RES},
    '{'{OP_POWER_ON, 16'h0000, 8'd0,   1'b1}, 1'b0, NO_RES},
    '{'{OP_POWER_ON, 16'h0000, 8'd0,   1'b1}, 1'b0, NO_RES},
    '{'{OP_POWER_ON, 16'h0000, 8'd0,   1'b1}, 1'b0, NO_RES},
    '{'{OP_TICK,     16'h01FE, 8'd255, 1'b0}, 1'b0, NO_RES},
    '{'{OP_TICK,     16'h0000, 8'd128, 1'b0}, 1'b0, NO_RES},
    '{'{OP_POWER_ON, 16'h0000, 8'd0,   1'b0}, 1'b1,
      '{12'd120, 1'b0, 1'b0, 1'b0, 1'b0, 8'd128, 12'd120, lrtl_pkg::MODE_UP}}
  };

  // phases after the first one, which runs on reset values
  localparam settings_t PHASES [5] = '{
    '{8'd0,   8'd255, 12'd11,   12'd4095, 12'd0,    8'd0},
    '{8'd255, 8'd0,   12'd4095, 12'd0,    12'd4095, 8'd255},
    '{8'd140, 8'd200, 12'd40,   12'd300,  12'd100,  8'd90},
    '{8'd180, 8'd220, 12'd200,  12'd900,  12'd400,  8'd200},
    '{8'd150, 8'd210, 12'd120,  12'd450,  12'd180,  8'd128}
  };

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = 1'b0;
  logic [15:0] temp_count = '0;
  logic [lrtl_pkg::CELL_W-1:0] cell_sample = '0;
  logic memory_kept = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [lrtl_pkg::LEVEL_W-1:0] light_level;
  logic full_on, idle_sleep, shut_down, save_limit;
  logic [lrtl_pkg::TEMP_W-1:0] temp_limit_out;
  logic [lrtl_pkg::LEVEL_W-1:0] user_level_out;
  logic [1:0] mode_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lrtl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lrtl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bit calm = 1'b0;
  int errors = 0;
  int idle_cycles = 0;
  light_result_t pending_results[$];

  // predicted configuration and controller state
  logic [7:0]      c_low, c_full, c_stored;
  logic [11:0]     c_min, c_max, c_thr;
  lrtl_pkg::mode_t st_mode;
  logic [11:0]     st_user, st_drive;
  logic [7:0]      st_filt, st_tlimit, st_clicks, st_ticks;
  bit              st_phase, st_marked, st_halted;

  led_ramp_thermal_limiter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .temp_count(temp_count), .cell_sample(cell_sample),
    .memory_kept(memory_kept),
    .out_valid(out_valid), .out_stall(out_stall),
    .light_level(light_level), .full_on(full_on), .idle_sleep(idle_sleep),
    .shut_down(shut_down), .save_limit(save_limit),
    .temp_limit_out(temp_limit_out), .user_level_out(user_level_out),
    .mode_out(mode_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic reset_light_model();
    c_low = lrtl_pkg::RST_LOW_CELL;
    c_full = lrtl_pkg::RST_FULL_CELL;
    c_min = lrtl_pkg::RST_LEVEL_MIN;
    c_max = lrtl_pkg::RST_LEVEL_MAX;
    c_thr = lrtl_pkg::RST_THERMAL_THR;
    c_stored = lrtl_pkg::RST_STORED_LIMIT;
    st_mode = lrtl_pkg::MODE_UP;
    st_user = c_min;
    st_drive = c_min;
    st_filt = c_full;
    st_tlimit = c_stored;
    st_clicks = '0;
    st_ticks = '0;
    st_phase = 1'b0;
    st_marked = 1'b0;
    st_halted = 1'b0;
  endtask

  function automatic light_result_t predict_light(light_event_t ev);
    light_result_t r;
    logic [7:0] temp;
    int step, lvl, diff, sign, filt, hi, lo, s;
    r = '0;
    temp = ev.temp_count[8:1];
    if (ev.op == OP_POWER_ON) begin
      st_filt = c_full;
      st_ticks = '0;
      st_phase = 1'b0;
      st_halted = 1'b0;
      if (st_user >= c_max) st_user = c_max;
      if (st_marked && ev.mem_kept) begin
        st_clicks = st_clicks + 8'd1;
        if (st_clicks == 8'd1) begin
          if (st_mode == lrtl_pkg::MODE_UP || st_mode == lrtl_pkg::MODE_DOWN)
            st_mode = lrtl_pkg::MODE_STEADY;
          else if (st_mode == lrtl_pkg::MODE_STEADY) st_mode = lrtl_pkg::MODE_UP;
          else r.save_limit = 1'b1;
        end else if (st_clicks == 8'd2) begin
          st_mode = lrtl_pkg::MODE_DOWN;
        end else begin
          st_mode = lrtl_pkg::MODE_STEADY;
          if (st_clicks > lrtl_pkg::CLICK_THERMAL) begin
            st_mode = lrtl_pkg::MODE_THERMAL;
            st_user = c_max;
          end
        end
      end else begin
        st_marked = 1'b1;
        st_user = c_min;
        st_mode = lrtl_pkg::MODE_UP;
        st_clicks = '0;
        st_tlimit = c_stored;
      end
      st_drive = st_user;
      r.level = st_drive;
    end else if (st_halted) begin
      r.shut_down = 1'b1;
    end else begin
      st_ticks = st_ticks + 8'd1;
      if (st_ticks == lrtl_pkg::CLICK_RESET_TICK) st_clicks = '0;
      if (st_mode == lrtl_pkg::MODE_THERMAL) st_tlimit = temp;
      if (st_mode == lrtl_pkg::MODE_UP) begin
        if (st_user != lrtl_pkg::LEVEL_TOP) st_user = st_user + 12'd1;
        if (st_user >= c_max) st_mode = lrtl_pkg::MODE_STEADY;
      end
      if (st_mode == lrtl_pkg::MODE_DOWN) begin
        // user level moves down only every second tick
        if (st_phase) begin
          st_phase = 1'b0;
          if (st_user != '0) st_user = st_user - 12'd1;
          if (st_user <= c_min) st_mode = lrtl_pkg::MODE_STEADY;
        end else begin
          st_phase = 1'b1;
        end
      end
      filt = st_filt;
      step = filt - int'(c_low);
      if (step > 127) step = 127;
      if (step < -128) step = -128;
      if (st_drive >= c_thr && st_mode != lrtl_pkg::MODE_THERMAL) begin
        diff = int'(temp) - int'(st_tlimit);
        sign = diff > 0 ? -1 : (diff == 0 ? 0 : 1);
        if (sign < step) step = sign;
      end
      lvl = int'(st_drive) + step;
      if (lvl < 0) lvl = 0;
      if (lvl > int'(lrtl_pkg::LEVEL_TOP)) lvl = int'(lrtl_pkg::LEVEL_TOP);
      if (int'(st_user) < lvl) lvl = int'(st_user);
      if (lvl + int'(lrtl_pkg::SHUTDOWN_MARGIN) < int'(c_min)) begin
        st_halted = 1'b1;
        r.shut_down = 1'b1;
      end else begin
        st_drive = lvl[11:0];
        s = ev.cell_in;
        hi = s < 255 ? s + 1 : 255;
        lo = s > 0 ? s - 1 : 0;
        if (hi < filt) filt = hi;
        if (lo > filt) filt = lo;
        st_filt = filt[7:0];
        r.level = st_drive;
        r.full_on = (st_drive == c_max);
        r.idle_sleep = (st_drive >= c_thr);
      end
    end
    r.heat_limit = st_tlimit;
    r.user_level = st_user;
    r.mode = st_mode;
    return r;
  endfunction

  task automatic send_event(light_event_t ev, logic typed, light_result_t typed_res);
    light_result_t r;
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= ev.op;
    temp_count <= ev.temp_count;
    cell_sample <= ev.cell_in;
    memory_kept <= ev.mem_kept;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_light(ev);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic write_reg(lrtl_pkg::cfg_reg_t idx, logic [11:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lrtl_pkg::REG_LOW_CELL:     c_low = data[7:0];
      lrtl_pkg::REG_FULL_CELL:    c_full = data[7:0];
      lrtl_pkg::REG_LEVEL_MIN:    c_min = data;
      lrtl_pkg::REG_LEVEL_MAX:    c_max = data;
      lrtl_pkg::REG_THERMAL_THR:  c_thr = data;
      lrtl_pkg::REG_STORED_LIMIT: c_stored = data[7:0];
      default: ;
    endcase
  endtask

  task automatic drain_and_load(settings_t s);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(lrtl_pkg::REG_LOW_CELL, {4'd0, s.low_cell});
    write_reg(lrtl_pkg::REG_FULL_CELL, {4'd0, s.full_cell});
    write_reg(lrtl_pkg::REG_LEVEL_MIN, s.lvl_min);
    write_reg(lrtl_pkg::REG_LEVEL_MAX, s.lvl_max);
    write_reg(lrtl_pkg::REG_THERMAL_THR, s.thermal_thr);
    write_reg(lrtl_pkg::REG_STORED_LIMIT, {4'd0, s.stored_limit});
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int count);
    light_event_t ev;
    int sent, pick, burst, lo, hi;
    logic [6:0] tc_top;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      ev.temp_count = 16'($urandom);
      ev.cell_in = 8'($urandom);
      ev.mem_kept = 1'($urandom);
      if (pick < 5) begin
        // click burst, long enough at times to reach thermal config
        burst = $urandom_range(1, 13);
        ev.op = OP_POWER_ON;
        ev.mem_kept = 1'b1;
        repeat (burst) send_event(ev, 1'b0, NO_RES);
        sent += burst;
      end else if (pick < 10) begin
        ev.op = OP_POWER_ON;
        ev.mem_kept = ($urandom_range(0, 9) < 7);
        send_event(ev, 1'b0, NO_RES);
        sent++;
      end else begin
        ev.op = OP_TICK;
        if ($urandom_range(0, 6) == 0) begin
          // temperature right at the limit
          tc_top = 7'($urandom);
          ev.temp_count = {tc_top, st_tlimit, 1'($urandom)};
        end
        if ($urandom_range(0, 9) < 6) begin
          lo = int'(c_low) - 20;
          hi = int'(c_low) + 60;
          if (lo < 0) lo = 0;
          if (hi > 255) hi = 255;
          ev.cell_in = 8'($urandom_range(lo, hi));
        end
        send_event(ev, 1'b0, NO_RES);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(0, 99) < 29);
  end

  task automatic cmp_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    light_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, level %0d mode %0d", $time,
                 light_level, mode_out);
        errors++;
      end else begin
        want = pending_results.pop_front();
        cmp_field("light_level", want.level, light_level);
        cmp_field("full_on", 12'(want.full_on), 12'(full_on));
        cmp_field("idle_sleep", 12'(want.idle_sleep), 12'(idle_sleep));
        cmp_field("shut_down", 12'(want.shut_down), 12'(shut_down));
        cmp_field("save_limit", 12'(want.save_limit), 12'(save_limit));
        cmp_field("temp_limit_out", 12'(want.heat_limit), 12'(temp_limit_out));
        cmp_field("user_level_out", want.user_level, user_level_out);
        cmp_field("mode_out", 12'(want.mode), 12'(mode_out));
      end
    end
  end

  // ends the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_led_ramp_thermal_limiter: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_light_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED[i]) send_event(DIRECTED[i].ev, DIRECTED[i].typed, DIRECTED[i].res);
    run_random(RANDOM_PER_PHASE);
    foreach (PHASES[p]) begin
      drain_and_load(PHASES[p]);
      calm = (p == 2);
      run_random(p == 1 ? RANDOM_PER_PHASE / 2 : RANDOM_PER_PHASE);
      calm = 1'b0;
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_led_ramp_thermal_limiter: PASS");
    end else begin
      $display("tb_led_ramp_thermal_limiter: FAIL");
    end
    $finish;
  end

endmodule

// File: led_ramp_thermal_limiter.f
rtl/lrtl_pkg.sv
rtl/led_ramp_thermal_limiter.sv
sim/tb_led_ramp_thermal_limiter.sv
